### sv/assert_macros.svh
// Assertion macros used by the checker file srb_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Plain property, sampled on clk, off during reset.
`define SRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition implies consequence in the same cycle.
`define SRB_ASSERT_IMPL(lbl, cond, cons, msg) \
  `SRB_ASSERT(lbl, (cond) |-> (cons), msg)
`endif

### sv/srb_pkg.sv
// Types and constants of the scaled raster-op blit unit.
package srb_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [2:0] ROP_COPY   = 3'd0;
  localparam logic [2:0] ROP_AND    = 3'd1;
  localparam logic [2:0] ROP_XOR    = 3'd2;
  localparam logic [2:0] ROP_OR     = 3'd3;
  localparam logic [2:0] ROP_NSRC   = 3'd4;
  localparam logic [2:0] ROP_INVDST = 3'd5;
  localparam logic [2:0] ROP_BLACK  = 3'd6;
  localparam logic [2:0] ROP_WHITE  = 3'd7;

  localparam int CFG_IDX_BITS = 4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_RECT    = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_RECT    = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_BOUNDS  = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_BOUNDS  = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RASTER_MODE = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BG_COLOR    = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_WHITE_VALUE = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_MONO_DEST   = 4'd7;

  localparam logic [7:0]  PIX_FF      = 8'hFF;
  localparam logic [31:0] WHITE_RESET = 32'd255;

  typedef struct packed {
    logic        command;
    logic [31:0] src_pixel;
    logic [31:0] dst_pixel;
  } in_t;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] new_pixel;
    logic [15:0] next_src_x;
    logic [15:0] next_src_y;
    logic [15:0] next_dst_x;
    logic [15:0] next_dst_y;
    logic        next_skip;
    logic        done_res;
  } out_t;

  typedef struct packed {
    logic [63:0] src_rect;
    logic [63:0] dst_rect;
    logic [31:0] src_bounds;
    logic [31:0] dst_bounds;
    logic [2:0]  raster_mode;
    logic [31:0] bg_color;
    logic [31:0] white_value;
    logic        mono_dest;
  } cfg_t;

  // Work handed from front to back.
  typedef struct packed {
    logic        wr_cand;
    logic        active;
    logic [15:0] col;
    logic [15:0] row;
    logic [31:0] pix;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_PUSH
  } back_state_t;

endpackage

### sv/scaled_raster_op_blit_unit.sv
// Scaled raster-op blit unit: a beat walking a destination rectangle is decoded
// combinationally in the front, then takes a walk step in the back
// (a multiply step, then one quotient bit per cycle); a done beat skips both.
// The back-end divider limits throughput; a 2-deep queue sits on each side.
// Synchronous active-high rst clears queues, walk state and registers;
// white_value resets to 255.
module scaled_raster_op_blit_unit #(
  parameter int PIXEL_BITS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  srb_pkg::in_t                       item,
  output logic                               empty,
  input  logic                               pop,
  output srb_pkg::out_t                      result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [srb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [63:0]                        cfg_data
);
  import srb_pkg::*;

  cfg_t cfg;
  job_t job_w, job_r;
  out_t res_w;
  logic job_empty, job_pop, res_full, res_push, accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{white_value: WHITE_RESET, default: '0};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_RECT:    cfg.src_rect    <= cfg_data;
        REG_DST_RECT:    cfg.dst_rect    <= cfg_data;
        REG_SRC_BOUNDS:  cfg.src_bounds  <= cfg_data[31:0];
        REG_DST_BOUNDS:  cfg.dst_bounds  <= cfg_data[31:0];
        REG_RASTER_MODE: cfg.raster_mode <= cfg_data[2:0];
        REG_BG_COLOR:    cfg.bg_color    <= cfg_data[31:0];
        REG_WHITE_VALUE: cfg.white_value <= cfg_data[31:0];
        REG_MONO_DEST:   cfg.mono_dest   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  srb_front #(.PIXEL_BITS(PIXEL_BITS), .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .accept(accept), .item(item), .job(job_w)
  );

  srb_fifo #(.W($bits(job_t))) u_jobq (
    .clk(clk), .rst(rst), .wr(push), .wdata(job_w), .full(full),
    .rd(job_pop), .rdata(job_r), .empty(job_empty)
  );

  srb_back #(.PIXEL_BITS(PIXEL_BITS), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .job_empty(job_empty), .job_in(job_r),
    .job_pop(job_pop), .res_full(res_full), .res_push(res_push), .res(res_w)
  );

  srb_fifo #(.W($bits(out_t))) u_resq (
    .clk(clk), .rst(rst), .wr(res_push), .wdata(res_w), .full(res_full),
    .rd(pop), .rdata(result), .empty(empty)
  );
endmodule

### sv/srb_fifo.sv
// Small register queue used between the stages and on the result side.
module srb_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         do_wr;
  logic         do_rd;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (do_rd) rptr <= ~rptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule

### sv/srb_front.sv
// Front end: decodes beats, steps the walk offsets, computes the raster result.
module srb_front #(
  parameter int PIXEL_BITS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  srb_pkg::cfg_t cfg,
  input  logic          accept,
  input  srb_pkg::in_t  item,
  output srb_pkg::job_t job
);
  import srb_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PB = PIXEL_BITS;

  logic [CB-1:0] col;
  logic [CB-1:0] row;
  logic          active;
  logic [CB-1:0] col_next;
  logic [CB-1:0] row_next;
  logic          active_next;

  logic [CB-1:0] sw, sh, dw, dh;
  logic          sizes_ok;
  logic [CB:0]   c_inc;
  logic [CB:0]   r_inc;
  logic          wrap;
  logic          walk_end;

  logic [PB-1:0] s, d, r, res;

  assign sw = cfg.src_rect[32 +: CB];
  assign sh = cfg.src_rect[48 +: CB];
  assign dw = cfg.dst_rect[32 +: CB];
  assign dh = cfg.dst_rect[48 +: CB];
  assign sizes_ok = (sw != '0) && (sh != '0) && (dw != '0) && (dh != '0);

  assign c_inc    = {1'b0, col} + (CB+1)'(1);
  assign wrap     = c_inc >= {1'b0, dw};
  assign r_inc    = {1'b0, row} + (CB+1)'(wrap);
  assign walk_end = (r_inc >= {1'b0, dh}) || !sizes_ok;

  always_comb begin
    col_next    = col;
    row_next    = row;
    active_next = active;
    if (item.command == CMD_START) begin
      col_next    = '0;
      row_next    = '0;
      active_next = sizes_ok;
    end else if (active) begin
      if (walk_end) begin
        col_next    = '0;
        row_next    = '0;
        active_next = 1'b0;
      end else begin
        col_next = wrap ? '0 : c_inc[CB-1:0];
        row_next = r_inc[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      active <= 1'b0;
    end else if (accept) begin
      col    <= col_next;
      row    <= row_next;
      active <= active_next;
    end
  end

  assign s = item.src_pixel[PB-1:0];
  assign d = item.dst_pixel[PB-1:0];

  always_comb begin
    r   = s;
    res = '0;
    unique case (cfg.raster_mode)
      ROP_COPY:   r = s;
      ROP_AND:    r = d & s;
      ROP_XOR:    r = d ^ s;
      ROP_OR:     r = d | s;
      default:    r = s;
    endcase
    unique case (cfg.raster_mode)
      ROP_COPY, ROP_AND, ROP_XOR, ROP_OR: begin
        if (cfg.mono_dest) res = (32'(r) == cfg.bg_color) ? PB'(PIX_FF) : '0;
        else res = r;
      end
      ROP_NSRC: begin
        if (cfg.mono_dest) res = (32'(s) == cfg.bg_color) ? '0 : PB'(PIX_FF);
        else res = ~s;
      end
      ROP_INVDST: res = ~d;
      ROP_BLACK:  res = '0;
      ROP_WHITE:  res = cfg.white_value[PB-1:0];
      default:    res = '0;
    endcase
  end

  always_comb begin
    job.wr_cand = (item.command == CMD_PIXEL) && active;
    job.active  = active_next;
    job.col     = 16'(col_next);
    job.row     = 16'(row_next);
    job.pix     = 32'(res);
  end
endmodule

### sv/srb_back.sv
// Back end: maps offsets to source coordinates by shift-subtract division.
module srb_back #(
  parameter int PIXEL_BITS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  srb_pkg::cfg_t cfg,
  input  logic          job_empty,
  input  srb_pkg::job_t job_in,
  output logic          job_pop,
  input  logic          res_full,
  output logic          res_push,
  output srb_pkg::out_t res
);
  import srb_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PB = PIXEL_BITS;
  localparam int NSTEP = 2 * CB;
  localparam int CW = $clog2(NSTEP);

  back_state_t state, state_next;
  job_t          jb;
  logic          pending_skip;
  logic [CW-1:0] cnt;
  logic [2*CB-1:0] dvd_x, dvd_y;
  logic [CB-1:0]   rem_x, rem_y;

  logic [CB-1:0] sw, sh, dw, dh;
  logic [CB:0]   tx, ty;
  logic          gx, gy;
  logic [CB:0]   sx, sy, dx, dy;
  logic          skip;
  logic          mul_go, div_go, last_step;

  assign sw = cfg.src_rect[32 +: CB];
  assign sh = cfg.src_rect[48 +: CB];
  assign dw = cfg.dst_rect[32 +: CB];
  assign dh = cfg.dst_rect[48 +: CB];

  assign last_step = (cnt == CW'(NSTEP - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!job_empty) state_next = job_in.active ? B_MUL : B_PUSH;
      B_MUL:  state_next = B_DIV;
      B_DIV:  if (last_step) state_next = B_PUSH;
      B_PUSH: if (!res_full) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = 1'b0;
    mul_go   = 1'b0;
    div_go   = 1'b0;
    res_push = 1'b0;
    unique case (state)
      B_IDLE: job_pop  = !job_empty;
      B_MUL:  mul_go   = 1'b1;
      B_DIV:  div_go   = 1'b1;
      B_PUSH: res_push = !res_full;
      default: ;
    endcase
  end

  // One quotient bit per cycle for both axes.
  assign tx = {rem_x, dvd_x[2*CB-1]};
  assign ty = {rem_y, dvd_y[2*CB-1]};
  assign gx = tx >= {1'b0, dw};
  assign gy = ty >= {1'b0, dh};

  always_ff @(posedge clk) begin
    if (job_pop) jb <= job_in;
    if (mul_go) begin
      dvd_x <= jb.col[CB-1:0] * sw;
      dvd_y <= jb.row[CB-1:0] * sh;
      rem_x <= '0;
      rem_y <= '0;
      cnt   <= '0;
    end else if (div_go) begin
      rem_x <= gx ? CB'(tx - {1'b0, dw}) : tx[CB-1:0];
      rem_y <= gy ? CB'(ty - {1'b0, dh}) : ty[CB-1:0];
      dvd_x <= {dvd_x[2*CB-2:0], gx};
      dvd_y <= {dvd_y[2*CB-2:0], gy};
      cnt   <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      pending_skip <= 1'b0;
    end else begin
      state <= state_next;
      if (res_push) pending_skip <= jb.active && skip;
    end
  end

  assign sx = {1'b0, cfg.src_rect[0 +: CB]}  + {1'b0, dvd_x[CB-1:0]};
  assign sy = {1'b0, cfg.src_rect[16 +: CB]} + {1'b0, dvd_y[CB-1:0]};
  assign dx = {1'b0, cfg.dst_rect[0 +: CB]}  + {1'b0, jb.col[CB-1:0]};
  assign dy = {1'b0, cfg.dst_rect[16 +: CB]} + {1'b0, jb.row[CB-1:0]};
  assign skip = (sx >= {1'b0, cfg.src_bounds[0 +: CB]})
             || (sy >= {1'b0, cfg.src_bounds[16 +: CB]})
             || (dx >= {1'b0, cfg.dst_bounds[0 +: CB]})
             || (dy >= {1'b0, cfg.dst_bounds[16 +: CB]});

  always_comb begin
    res.write_valid = jb.wr_cand && !pending_skip;
    res.new_pixel   = res.write_valid ? 32'(jb.pix[PB-1:0]) : '0;
    res.done_res    = !jb.active;
    res.next_src_x  = jb.active ? 16'(sx[CB-1:0]) : '0;
    res.next_src_y  = jb.active ? 16'(sy[CB-1:0]) : '0;
    res.next_dst_x  = jb.active ? 16'(dx[CB-1:0]) : '0;
    res.next_dst_y  = jb.active ? 16'(dy[CB-1:0]) : '0;
    res.next_skip   = jb.active && skip;
  end
endmodule

### sv/srb_checker.sv
// Port-level checks on the blit unit's result queue, with bind.
`include "assert_macros.svh"
module srb_checker (
  input logic          clk,
  input logic          rst,
  input logic          empty,
  input logic          pop,
  input srb_pkg::out_t result
);
  `SRB_ASSERT_IMPL(a_done_zero, !empty && result.done_res, (result.next_src_x == 16'd0) && (result.next_src_y == 16'd0) && (result.next_dst_x == 16'd0) && (result.next_dst_y == 16'd0), "done result carries coordinates")
  `SRB_ASSERT_IMPL(a_nowrite_zero, !empty && !result.write_valid, result.new_pixel == 32'd0, "pixel without write")
  `SRB_ASSERT_IMPL(a_done_noskip, !empty && result.done_res, !result.next_skip, "skip on done result")
  `SRB_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(result)), "waiting result changed")
endmodule

bind scaled_raster_op_blit_unit srb_checker u_srb_checker (.*);

### tb/sv/scaled_raster_op_blit_unit_checker.sv
// Checker for the scaled raster-op blit unit: predicts each result beat and compares.
module scaled_raster_op_blit_unit_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic                             full,
  input  srb_pkg::in_t                     item,
  input  logic                             empty,
  input  logic                             pop,
  input  srb_pkg::out_t                    result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [srb_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [63:0]                      cfg_data,
  output int                               fail_count,
  output int                               pending
);
  import srb_pkg::*;

  cfg_t        regs;
  logic [15:0] col_off, row_off;
  logic        walking, skip_pend;
  out_t        expected_beats[$];

  assign pending = expected_beats.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic logic [15:0] rfield(input logic [63:0] r, input int k);
    return r[16*k +: 16];
  endfunction

  function automatic logic sizes_nonzero();
    return rfield(regs.src_rect, 2) != 0 && rfield(regs.src_rect, 3) != 0 &&
           rfield(regs.dst_rect, 2) != 0 && rfield(regs.dst_rect, 3) != 0;
  endfunction

  function automatic logic [31:0] rop_pixel(input logic [31:0] s, input logic [31:0] d);
    logic [31:0] r;
    case (regs.raster_mode)
      ROP_COPY:   r = s;
      ROP_AND:    r = d & s;
      ROP_XOR:    r = d ^ s;
      ROP_OR:     r = d | s;
      ROP_NSRC:   return regs.mono_dest ? ((s == regs.bg_color) ? 32'd0 : 32'(PIX_FF)) : ~s;
      ROP_INVDST: return ~d;
      ROP_BLACK:  return 32'd0;
      default:    return regs.white_value;
    endcase
    if (regs.mono_dest) r = (r == regs.bg_color) ? 32'(PIX_FF) : 32'd0;
    return r;
  endfunction

  // Advances the walk by one beat and returns the expected result.
  function automatic out_t step_walk(input in_t it);
    out_t o;
    logic [31:0] c, r, sx, sy, dx, dy;
    logic sk;
    o = '0;
    if (it.command == CMD_START) begin
      col_off = 0; row_off = 0; skip_pend = 0;
      walking = sizes_nonzero();
    end else if (walking) begin
      c = col_off + 1; r = row_off;
      if (!skip_pend) begin
        o.write_valid = 1;
        o.new_pixel = rop_pixel(it.src_pixel, it.dst_pixel);
      end
      if (c >= rfield(regs.dst_rect, 2)) begin
        c = 0; r++;
      end
      col_off = c[15:0]; row_off = r[15:0];
      if (r >= rfield(regs.dst_rect, 3) || !sizes_nonzero()) begin
        walking = 0; col_off = 0; row_off = 0;
      end
      skip_pend = 0;
    end
    o.done_res = 1;
    if (walking) begin
      sx = rfield(regs.src_rect, 0) +
           32'((64'(col_off) * rfield(regs.src_rect, 2)) / rfield(regs.dst_rect, 2));
      sy = rfield(regs.src_rect, 1) +
           32'((64'(row_off) * rfield(regs.src_rect, 3)) / rfield(regs.dst_rect, 3));
      dx = rfield(regs.dst_rect, 0) + col_off;
      dy = rfield(regs.dst_rect, 1) + row_off;
      sk = sx >= regs.src_bounds[15:0] || sy >= regs.src_bounds[31:16] ||
           dx >= regs.dst_bounds[15:0] || dy >= regs.dst_bounds[31:16];
      skip_pend = sk;
      o.next_src_x = sx[15:0]; o.next_src_y = sy[15:0];
      o.next_dst_x = dx[15:0]; o.next_dst_y = dy[15:0];
      o.next_skip = sk; o.done_res = 0;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    out_t w;
    if (rst) begin
      regs = '0;
      regs.white_value = WHITE_RESET;
      col_off = 0; row_off = 0; walking = 0; skip_pend = 0;
      fail_count = 0;
      expected_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        case (cfg_index)
          REG_SRC_RECT:    regs.src_rect = cfg_data;
          REG_DST_RECT:    regs.dst_rect = cfg_data;
          REG_SRC_BOUNDS:  regs.src_bounds = cfg_data[31:0];
          REG_DST_BOUNDS:  regs.dst_bounds = cfg_data[31:0];
          REG_RASTER_MODE: regs.raster_mode = cfg_data[2:0];
          REG_BG_COLOR:    regs.bg_color = cfg_data[31:0];
          REG_WHITE_VALUE: regs.white_value = cfg_data[31:0];
          REG_MONO_DEST:   regs.mono_dest = cfg_data[0];
          default: ;
        endcase
      if (push && !full) expected_beats.push_back(step_walk(item));
      if (pop && !empty) begin
        if (expected_beats.size() == 0) report("unexpected beat", 0, 0);
        else begin
          w = expected_beats.pop_front();
          if (result.write_valid !== w.write_valid)
            report("write_valid", result.write_valid, w.write_valid);
          if (result.new_pixel !== w.new_pixel) report("new_pixel", result.new_pixel, w.new_pixel);
          if (result.next_src_x !== w.next_src_x)
            report("next_src_x", result.next_src_x, w.next_src_x);
          if (result.next_src_y !== w.next_src_y)
            report("next_src_y", result.next_src_y, w.next_src_y);
          if (result.next_dst_x !== w.next_dst_x)
            report("next_dst_x", result.next_dst_x, w.next_dst_x);
          if (result.next_dst_y !== w.next_dst_y)
            report("next_dst_y", result.next_dst_y, w.next_dst_y);
          if (result.next_skip !== w.next_skip) report("next_skip", result.next_skip, w.next_skip);
          if (result.done_res !== w.done_res) report("done_res", result.done_res, w.done_res);
        end
      end
    end
  end
endmodule

### tb/sv/scaled_raster_op_blit_unit_test.sv
// Testbench top for the scaled raster-op blit unit: stimulus, stalls and verdict.
module scaled_raster_op_blit_unit_test;
  import srb_pkg::*;

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0, full, empty, cfg_valid = 0, cfg_ready;
  in_t  item = '0;
  out_t result;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int   fail_count, pending;
  logic hold_off = 0;
  logic press = 0;

  scaled_raster_op_blit_unit dut (.*);
  scaled_raster_op_blit_unit_checker chk (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #4000000;
    $display("scaled_raster_op_blit_unit regression: fail");
    $finish;
  end

  // Long receiver hold-off, counted here, once the sender starts the pressure walk.
  initial begin
    @(posedge clk iff press);
    hold_off <= 1;
    repeat (400) @(posedge clk);
    hold_off <= 0;
  end

  // Receiver: own stall pattern, plus one long hold-off.
  initial begin
    int mode;
    @(posedge clk iff !rst);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk);
        if (hold_off) pop <= 0;
        else case (mode)
          0: pop <= 1;
          1: pop <= ($urandom_range(0, 3) != 0);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  int   burst_left = 0;

  // Closes an open burst so that no stale beat is offered.
  task automatic end_burst();
    if (burst_left != 0) begin
      push <= 0;
      burst_left = 0;
    end
  endtask

  // Let every expected beat drain, then the back end settle.
  task automatic drain();
    end_burst();
    @(posedge clk iff pending == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic send(input logic cmd, input logic [31:0] s, input logic [31:0] d);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    push <= 1;
    item <= '{command: cmd, src_pixel: s, dst_pixel: d};
    @(posedge clk iff !full);
    if (burst_left == 0) push <= 0;
  endtask

  function automatic logic [63:0] rect(input int l, input int t, input int w, input int h);
    return {16'(h), 16'(w), 16'(t), 16'(l)};
  endfunction

  task automatic walk(input int len);
    send(CMD_START, $urandom, $urandom);
    repeat (len) send(CMD_PIXEL, $urandom, $urandom);
  endtask

  task automatic random_setup(input logic wide);
    int sw, sh, dw, dh;
    sw = wide ? $urandom_range(1, 65535) : $urandom_range(0, 9);
    dw = wide ? 16'hffff : $urandom_range(1, 8);
    sh = $urandom_range(0, 7);
    dh = $urandom_range(1, 6);
    if ($urandom_range(0, 7) == 0) dh = 0;
    write_reg(REG_SRC_RECT, wide ? {$urandom, $urandom} :
              rect($urandom_range(0, 20), $urandom_range(0, 20), sw, sh));
    write_reg(REG_DST_RECT, wide ? {16'(dh), 16'(dw), $urandom} :
              rect($urandom_range(0, 20), $urandom_range(0, 20), dw, dh));
    write_reg(REG_SRC_BOUNDS, 64'(wide ? $urandom : {16'($urandom_range(0, 30)),
              16'($urandom_range(0, 30))}));
    write_reg(REG_DST_BOUNDS, 64'(wide ? $urandom : {16'($urandom_range(0, 30)),
              16'($urandom_range(0, 30))}));
    write_reg(REG_RASTER_MODE, 64'($urandom_range(0, 7)));
    write_reg(REG_BG_COLOR, ($urandom_range(0, 1)) ? 64'(PIX_FF) : 64'($urandom));
    write_reg(REG_WHITE_VALUE, {$urandom, $urandom});
    write_reg(REG_MONO_DEST, 64'($urandom_range(0, 1)));
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Pixel beats while idle, then a walk with zero sizes.
    send(CMD_PIXEL, 32'hffffffff, 32'h0);
    send(CMD_PIXEL, 32'h0, 32'hffffffff);
    walk(2);
    drain();
    write_reg(REG_SRC_RECT, rect(0, 0, 3, 2));
    write_reg(REG_DST_RECT, rect(0, 0, 4, 2));
    write_reg(REG_SRC_BOUNDS, 64'({16'd2, 16'd2}));
    write_reg(REG_DST_BOUNDS, 64'({16'hffff, 16'hffff}));
    write_reg(REG_MONO_DEST, 64'(1));
    write_reg(REG_BG_COLOR, 64'(PIX_FF));
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_RASTER_MODE, 64'(m));
      send(CMD_START, 0, 0);
      send(CMD_PIXEL, 32'hff, 32'hff);
      send(CMD_PIXEL, 32'h0, 32'hffffffff);
      drain();
    end
    write_reg(REG_MONO_DEST, 64'(0));
    write_reg(REG_WHITE_VALUE, 64'hffffffff);
    walk(10);
    drain();
    // Receiver holds off while a long walk keeps offering beats.
    press <= 1;
    walk(40);
    press <= 0;
    drain();
    // Random: mostly small walks, a few of maximum width.
    n = 0;
    while (n < 1150) begin
      random_setup($urandom_range(0, 15) == 0);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0) begin
          send(CMD_PIXEL, $urandom, $urandom);
          n++;
        end else begin
          walk($urandom_range(0, 40));
          n += 20;
        end
      end
      drain();
    end
    drain();
    if (fail_count == 0) $display("scaled_raster_op_blit_unit regression: pass");
    else $display("scaled_raster_op_blit_unit regression: fail");
    $finish;
  end
endmodule
